FILE: rtl/lzss_decompressor_core_defines.svh
// ----------------------------------------------------------------------------
// lzss_decompressor_core_defines.svh
// Assertion macros shared by the checkers of the LZSS decompressor.
// ----------------------------------------------------------------------------
`ifndef LZSS_DECOMPRESSOR_CORE_DEFINES_SVH
`define LZSS_DECOMPRESSOR_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define LZSS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define LZSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lzss_pkg.sv
// ----------------------------------------------------------------------------
// lzss_pkg
// Types and constants shared by the LZSS decompressor modules.
// ----------------------------------------------------------------------------
package lzss_pkg;

  localparam int DIST_W     = 12;
  localparam int LEN_W      = 5;   // 15 + MIN_MATCH (at most 8) fits
  localparam int COUNT_W    = 24;
  localparam int FIFO_DEPTH = 4;

  // command kinds passed from the parser to the copy engine
  localparam logic [1:0] CMD_LIT   = 2'd0;
  localparam logic [1:0] CMD_MATCH = 2'd1;
  localparam logic [1:0] CMD_CLOSE = 2'd2;

  // frame status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_TRUNC = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;

  // register map (word index)
  localparam logic REG_MAX_OUT_LEN = 1'b0;
  localparam logic [COUNT_W-1:0] MAX_OUT_LEN_RESET = 24'd65535;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         data;
    logic [DIST_W-1:0]  distance;
    logic [LEN_W-1:0]   len;
    logic               last;
    logic [1:0]         status;
    logic [COUNT_W-1:0] length;
  } cmd_t;

endpackage

FILE: rtl/lzss_ram.sv
// ----------------------------------------------------------------------------
// lzss_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lzss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/lzss_front.sv
// ----------------------------------------------------------------------------
// lzss_front
// Token parser: walks control bits, checks the output limit and the frame
// end, and turns each compressed word into at most one copy command.
// ----------------------------------------------------------------------------
module lzss_front
  import lzss_pkg::*;
#(
  parameter int MIN_MATCH = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  input  logic               in_last,
  input  logic [COUNT_W-1:0] max_out_len,
  input  logic               fifo_full,
  output logic               push,
  output cmd_t               cmd
);

  localparam logic [1:0] PH_CTRL = 2'd0;
  localparam logic [1:0] PH_OP   = 2'd1;
  localparam logic [1:0] PH_MLOW = 2'd2;

  logic [1:0]         phase, phase_next;
  logic [7:0]         ctrl, ctrl_next;
  logic [2:0]         bit_idx, bit_idx_next;
  logic [7:0]         mhigh, mhigh_next;
  logic [COUNT_W-1:0] count, count_next;
  logic [1:0]         err, err_next;

  logic               take;
  logic [LEN_W-1:0]   mlen;
  logic [COUNT_W:0]   mend;
  logic               emit_cmd;

  assign in_ready = !fifo_full;
  assign take     = in_valid && !fifo_full;
  assign mlen     = {1'b0, mhigh[3:0]} + LEN_W'(MIN_MATCH);
  assign mend     = {1'b0, count} + (COUNT_W+1)'(mlen);

  // parse one word
  always_comb begin
    phase_next   = phase;
    ctrl_next    = ctrl;
    bit_idx_next = bit_idx;
    mhigh_next   = mhigh;
    count_next   = count;
    err_next     = err;
    emit_cmd     = 1'b0;
    cmd.kind     = CMD_CLOSE;
    cmd.data     = in_byte;
    cmd.distance = {mhigh[7:4], in_byte};
    cmd.len      = mlen;
    cmd.last     = in_last;
    cmd.status   = ST_OK;
    cmd.length   = count;

    if (err == ST_OK) begin
      case (phase)
        PH_CTRL: begin
          ctrl_next    = in_byte;
          bit_idx_next = 3'd7;
          phase_next   = PH_OP;
        end
        PH_OP: begin
          if (ctrl[bit_idx]) begin
            if (in_last) begin
              err_next = ST_TRUNC;
            end else begin
              mhigh_next = in_byte;
              phase_next = PH_MLOW;
            end
          end else if (count >= max_out_len) begin
            err_next = ST_OVER;
          end else begin
            emit_cmd   = 1'b1;
            cmd.kind   = CMD_LIT;
            count_next = count + 1'b1;
          end
        end
        default: begin
          if (mend > {1'b0, max_out_len}) begin
            err_next = ST_OVER;
          end else begin
            emit_cmd   = 1'b1;
            cmd.kind   = CMD_MATCH;
            count_next = mend[COUNT_W-1:0];
          end
        end
      endcase
      // operation finished: step to next control bit
      if (emit_cmd) begin
        if (bit_idx == 3'd0) begin
          phase_next   = PH_CTRL;
          bit_idx_next = 3'd7;
        end else begin
          bit_idx_next = bit_idx - 1'b1;
          phase_next   = PH_OP;
        end
      end
    end

    cmd.status = err_next;
    cmd.length = count_next;
    push       = take && (emit_cmd || in_last);

    // frame end: per-frame state back to its start value
    if (in_last) begin
      phase_next   = PH_CTRL;
      ctrl_next    = 8'd0;
      bit_idx_next = 3'd7;
      mhigh_next   = 8'd0;
      count_next   = '0;
      err_next     = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_CTRL;
      ctrl    <= 8'd0;
      bit_idx <= 3'd7;
      mhigh   <= 8'd0;
      count   <= '0;
      err     <= ST_OK;
    end else if (take) begin
      phase   <= phase_next;
      ctrl    <= ctrl_next;
      bit_idx <= bit_idx_next;
      mhigh   <= mhigh_next;
      count   <= count_next;
      err     <= err_next;
    end
  end

endmodule

FILE: rtl/lzss_cmd_fifo.sv
// ----------------------------------------------------------------------------
// lzss_cmd_fifo
// Short command queue between the parser and the copy engine.
// ----------------------------------------------------------------------------
module lzss_cmd_fifo
  import lzss_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t head
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  cmd_t             slots [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] cnt;

  assign full  = (cnt == CNT_W'(FIFO_DEPTH));
  assign valid = (cnt != '0);
  assign head  = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && valid) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push && !full, pop && valid})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

FILE: rtl/lzss_back.sv
// ----------------------------------------------------------------------------
// lzss_back
// Copy engine: emits literals and window copies one word at a time, keeps
// the history window and drives the output register.
// ----------------------------------------------------------------------------
module lzss_back
  import lzss_pkg::*;
#(
  parameter int WINDOW_SIZE = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  cmd_t               cmd,
  output logic               cmd_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               byte_valid,
  output logic               run_last,
  output logic               frame_done,
  output logic [1:0]         frame_status,
  output logic [COUNT_W-1:0] out_length
);

  localparam int PTR_W  = $clog2(WINDOW_SIZE);
  localparam int PTR1_W = PTR_W + 1;
  localparam int FILL_W = $clog2(WINDOW_SIZE + 1);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_ONE  = 2'd1;
  localparam logic [1:0] B_RD   = 2'd2;
  localparam logic [1:0] B_DATA = 2'd3;

  logic [1:0]        state;
  cmd_t              cur;
  logic [LEN_W-1:0]  rem;
  logic              hit;
  logic [PTR_W-1:0]  ptr;
  logic [FILL_W-1:0] fill;

  logic              out_free;
  logic              emit;
  logic              is_byte;
  logic              final_word;
  logic              closing;
  logic [7:0]        emit_val;
  logic [7:0]        rd_data;
  logic [PTR1_W-1:0] diff;
  logic [PTR1_W-1:0] idx_wide;
  logic [PTR_W-1:0]  idx;
  logic [PTR_W-1:0]  ptr_adv;
  logic [FILL_W-1:0] fill_adv;

  // source position: pointer minus distance, wrapped into the window
  assign diff     = {1'b0, ptr} - PTR1_W'(cur.distance);
  assign idx_wide = diff[PTR_W] ? diff + PTR1_W'(WINDOW_SIZE) : diff;
  assign idx      = idx_wide[PTR_W-1:0];

  assign ptr_adv  = (ptr == PTR_W'(WINDOW_SIZE - 1)) ? '0 : ptr + 1'b1;
  assign fill_adv = (fill == FILL_W'(WINDOW_SIZE)) ? fill : fill + 1'b1;

  // emit control
  assign out_free   = !out_valid || out_ready;
  assign emit       = ((state == B_ONE) || (state == B_DATA)) && out_free;
  assign is_byte    = (state == B_DATA) || (cur.kind == CMD_LIT);
  assign final_word = (state == B_ONE) || (rem == LEN_W'(1));
  assign closing    = final_word && cur.last;
  assign emit_val   = (state == B_DATA) ? (hit ? rd_data : 8'd0) : cur.data;
  assign cmd_pop    = (state == B_IDLE) && cmd_valid;

  lzss_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_SIZE)
  ) u_window (
    .clk     (clk),
    .wr_en   (emit && is_byte),
    .wr_addr (ptr),
    .wr_data (emit_val),
    .rd_en   (state == B_RD),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      ptr       <= '0;
      fill      <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (cmd_valid) begin
            state <= (cmd.kind == CMD_MATCH) ? B_RD : B_ONE;
          end
        end
        B_RD: begin
          state <= B_DATA;
        end
        default: begin
          if (emit) begin
            state <= final_word ? B_IDLE : B_RD;
          end
        end
      endcase
      // window position; a closed frame starts over with an empty window
      if (emit) begin
        if (closing) begin
          ptr  <= '0;
          fill <= '0;
        end else if (is_byte) begin
          ptr  <= ptr_adv;
          fill <= fill_adv;
        end
      end
    end
  end

  // command and output payload
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd;
      rem <= cmd.len;
    end
    if (state == B_RD) begin
      hit <= (FILL_W'(idx) < fill);
    end
    if (emit) begin
      rem          <= rem - 1'b1;
      out_byte     <= is_byte ? emit_val : 8'd0;
      byte_valid   <= is_byte;
      run_last     <= final_word;
      frame_done   <= closing;
      frame_status <= closing ? cur.status : ST_OK;
      out_length   <= closing ? cur.length : '0;
    end
  end

endmodule

FILE: rtl/lzss_decompressor_core.sv
// ----------------------------------------------------------------------------
// lzss_decompressor_core
// LZSS decompressor with a history window: compressed words in, bytes out.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one compressed byte per word, in_last
// on the final byte of a frame. Output channel (out_valid/out_ready): one
// result per word, a decompressed byte or an empty word that closes the
// frame; frame_done marks the close with frame_status and out_length.
// max_out_len is set over the APB port at word address 0.
// The parser takes one input word per cycle while its command queue has
// room; control bytes, first match bytes and ignored bytes push a command only when they end the frame.
// The copy engine takes a command only when idle. It emits a literal or
// frame close from its B_ONE state; for each byte of a match of length
// L it reads the window RAM in B_RD, then writes and emits the byte in
// B_DATA. Every result word passes through the output register.
// Reset empties the queue and the output register and restores
// max_out_len to 65535; no window clearing pass is needed, a fill count
// hides unwritten entries. A stalled receiver holds the output word, then
// the copy engine, then the queue, and finally in_ready drops.
// ----------------------------------------------------------------------------
module lzss_decompressor_core
  import lzss_pkg::*;
#(
  parameter int WINDOW_SIZE = 4096,
  parameter int MIN_MATCH   = 3
) (
  input  logic               clk,
  input  logic               rst,
  // APB configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // compressed input
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  input  logic               in_last,
  // decompressed output
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               byte_valid,
  output logic               run_last,
  output logic               frame_done,
  output logic [1:0]         frame_status,
  output logic [COUNT_W-1:0] out_length
);

  logic [COUNT_W-1:0] max_out_len;
  logic               push;
  cmd_t               push_cmd;
  logic               fifo_full;
  logic               fifo_valid;
  cmd_t               head;
  logic               pop;

  // configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_out_len <= MAX_OUT_LEN_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_MAX_OUT_LEN)) begin
      max_out_len <= pwdata[COUNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MAX_OUT_LEN) begin
      prdata = {8'd0, max_out_len};
    end
  end

  lzss_front #(
    .MIN_MATCH (MIN_MATCH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .in_last     (in_last),
    .max_out_len (max_out_len),
    .fifo_full   (fifo_full),
    .push        (push),
    .cmd         (push_cmd)
  );

  lzss_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (fifo_full),
    .pop      (pop),
    .valid    (fifo_valid),
    .head     (head)
  );

  lzss_back #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (fifo_valid),
    .cmd          (head),
    .cmd_pop      (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .run_last     (run_last),
    .frame_done   (frame_done),
    .frame_status (frame_status),
    .out_length   (out_length)
  );

endmodule

FILE: rtl/lzss_chk.sv
// ----------------------------------------------------------------------------
// lzss_chk
// Port-level checker for the LZSS decompressor, bound to the top level.
// ----------------------------------------------------------------------------
`include "lzss_decompressor_core_defines.svh"

module lzss_chk (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        byte_valid,
  input logic        run_last,
  input logic        frame_done,
  input logic [1:0]  frame_status,
  input logic [23:0] out_length
);

  // an empty word only ever closes a frame
  `LZSS_ASSERT_IMPL(a_empty_closes, clk, rst, out_valid && !byte_valid, frame_done && run_last && (out_byte == 8'd0), "empty output word does not close a frame")

  // status and length are shown only with the frame close
  `LZSS_ASSERT_IMPL(a_status_quiet, clk, rst, out_valid && !frame_done, (frame_status == 2'd0) && (out_length == 24'd0), "status or length set outside frame close")

  // the frame close is the last word of its input word
  `LZSS_ASSERT_IMPL(a_close_last, clk, rst, out_valid && frame_done, run_last, "frame close is not the last word of its input")

  // a stalled output word holds
  `LZSS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(run_last), "stalled output word changed")

endmodule

bind lzss_decompressor_core lzss_chk u_lzss_chk (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_byte     (out_byte),
  .byte_valid   (byte_valid),
  .run_last     (run_last),
  .frame_done   (frame_done),
  .frame_status (frame_status),
  .out_length   (out_length)
);

FILE: tb/lzss_decompressor_core_tb.sv
// ----------------------------------------------------------------------------
// lzss_decompressor_core_tb
// Self-checking bench for the LZSS decompressor core. Compressed frames go in
// over the valid/ready input channel. A bit-accurate decoder in the bench
// predicts every output word, and each accepted output word is compared
// field by field in order. Directed frames cover literals, matches at the
// field extremes, unwritten window reads, truncation and the output limit.
// Random frames follow, under changing stall patterns and output limits.
// ----------------------------------------------------------------------------
module lzss_decompressor_core_tb;
  import lzss_pkg::*;

  localparam int WIN_SIZE = 4096;
  localparam int MATCH_MIN = 3;
  localparam logic [2:0] LIMIT_ADDR = 3'(4 * REG_MAX_OUT_LEN);
  localparam logic [COUNT_W-1:0] LIMIT_TOP = '1;
  localparam int SETTLE_CYCLES = 64;
  localparam int DRAIN_CYCLES = 20000;
  localparam int MAX_PRINTED = 50;

  typedef enum logic [1:0] {
    EXPECT_CTRL,
    EXPECT_OP,
    EXPECT_DIST_LO
  } parse_state_t;

  typedef struct packed {
    logic [7:0]         data;
    logic               is_byte;
    logic               run_end;
    logic               closes;
    logic [1:0]         status;
    logic [COUNT_W-1:0] length;
  } out_word_t;

  // DUT signals
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_byte = '0;
  logic               in_last = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         out_byte;
  logic               byte_valid;
  logic               run_last;
  logic               frame_done;
  logic [1:0]         frame_status;
  logic [COUNT_W-1:0] out_length;

  // stall rates in percent
  int unsigned tx_idle_pct = 37;
  int unsigned rx_idle_pct = 62;

  int unsigned mismatch_count = 0;
  int unsigned words_sent = 0;
  int unsigned words_seen = 0;

  // decoder model state
  out_word_t          decoded_q[$];
  out_word_t          step_words[$];
  parse_state_t       dec_phase;
  logic [7:0]         dec_ctrl;
  logic [2:0]         dec_bit;
  logic [7:0]         dec_hi;
  logic [7:0]         window_mem[WIN_SIZE];
  logic [11:0]        win_ptr;
  logic [12:0]        win_fill;
  logic [COUNT_W-1:0] frame_count;
  logic [1:0]         frame_err;
  logic [COUNT_W-1:0] limit_reg;

  lzss_decompressor_core #(
    .WINDOW_SIZE(WIN_SIZE),
    .MIN_MATCH  (MATCH_MIN)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .in_last     (in_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .byte_valid  (byte_valid),
    .run_last    (run_last),
    .frame_done  (frame_done),
    .frame_status(frame_status),
    .out_length  (out_length)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------------

  function automatic void restart_frame();
    dec_phase = EXPECT_CTRL;
    dec_ctrl = '0;
    dec_bit = 3'd7;
    dec_hi = '0;
    win_ptr = '0;
    win_fill = '0;
    frame_count = '0;
    frame_err = ST_OK;
  endfunction

  function automatic void emit_byte(input logic [7:0] b);
    out_word_t w;
    w = '0;
    w.data = b;
    w.is_byte = 1'b1;
    step_words.push_back(w);
    window_mem[win_ptr] = b;
    win_ptr = win_ptr + 1'b1;
    if (win_fill < WIN_SIZE) win_fill = win_fill + 1'b1;
    frame_count = frame_count + 1'b1;
  endfunction

  // step to the next op, or back to a control byte after eight
  function automatic void next_op();
    if (dec_bit == 3'd0) begin
      dec_phase = EXPECT_CTRL;
      dec_bit = 3'd7;
    end else begin
      dec_bit = dec_bit - 1'b1;
      dec_phase = EXPECT_OP;
    end
  endfunction

  // expected output words for one accepted compressed word
  function automatic void decode_word(input logic [7:0] b, input logic last);
    logic [11:0] distance;
    logic [11:0] idx;
    int unsigned run_len;
    out_word_t   w;
    step_words.delete();
    if (frame_err == ST_OK) begin
      case (dec_phase)
        EXPECT_CTRL: begin
          dec_ctrl = b;
          dec_bit = 3'd7;
          dec_phase = EXPECT_OP;
        end
        EXPECT_OP: begin
          if (dec_ctrl[dec_bit]) begin
            if (last) begin
              frame_err = ST_TRUNC;
            end else begin
              dec_hi = b;
              dec_phase = EXPECT_DIST_LO;
            end
          end else if (frame_count >= limit_reg) begin
            frame_err = ST_OVER;
          end else begin
            emit_byte(b);
            next_op();
          end
        end
        default: begin
          distance = {dec_hi[7:4], b};
          run_len = dec_hi[3:0] + MATCH_MIN;
          if (frame_count + run_len > limit_reg) begin
            frame_err = ST_OVER;
          end else begin
            // byte by byte, so overlapping copies repeat
            repeat (run_len) begin
              idx = win_ptr - distance;
              emit_byte((idx < win_fill) ? window_mem[idx] : 8'h00);
            end
            next_op();
          end
        end
      endcase
    end
    // frame close rides on the last byte word, or on an empty word
    if (last) begin
      if (step_words.size() == 0) begin
        w = '0;
        step_words.push_back(w);
      end
      w = step_words.pop_back();
      w.closes = 1'b1;
      w.status = frame_err;
      w.length = frame_count;
      step_words.push_back(w);
      restart_frame();
    end
    if (step_words.size() != 0) begin
      w = step_words.pop_back();
      w.run_end = 1'b1;
      step_words.push_back(w);
    end
    foreach (step_words[k]) decoded_q.push_back(step_words[k]);
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random stalls and the in-order check
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin : check_out
    out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (decoded_q.size() == 0) begin
        report_mismatch($sformatf("output word %0d with nothing expected", words_seen));
      end else begin
        want = decoded_q.pop_front();
        if (out_byte !== want.data)
          report_mismatch($sformatf("word %0d out_byte %0h exp %0h",
                                    words_seen, out_byte, want.data));
        if (byte_valid !== want.is_byte)
          report_mismatch($sformatf("word %0d byte_valid %0b exp %0b",
                                    words_seen, byte_valid, want.is_byte));
        if (run_last !== want.run_end)
          report_mismatch($sformatf("word %0d run_last %0b exp %0b",
                                    words_seen, run_last, want.run_end));
        if (frame_done !== want.closes)
          report_mismatch($sformatf("word %0d frame_done %0b exp %0b",
                                    words_seen, frame_done, want.closes));
        if (frame_status !== want.status)
          report_mismatch($sformatf("word %0d frame_status %0d exp %0d",
                                    words_seen, frame_status, want.status));
        if (out_length !== want.length)
          report_mismatch($sformatf("word %0d out_length %0d exp %0d",
                                    words_seen, out_length, want.length));
      end
      words_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // one compressed word; valid stays up after acceptance unless a gap follows
  task automatic send_word(input logic [7:0] b, input logic last);
    int unsigned gap;
    if ($urandom_range(99) < tx_idle_pct) begin
      gap = ($urandom_range(7) == 0) ? $urandom_range(12, 5) : $urandom_range(3, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_last <= last;
    do @(posedge clk); while (!in_ready);
    decode_word(b, last);
    words_sent++;
  endtask

  task automatic send_frame(input logic [7:0] frame[$]);
    foreach (frame[k]) send_word(frame[k], k == frame.size() - 1);
  endtask

  // hold off input until every expected word is out, then let the core settle
  task automatic drain_output();
    in_valid <= 1'b0;
    do @(posedge clk); while (decoded_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write of the output limit, then a read back
  task automatic write_limit(input logic [COUNT_W-1:0] value);
    logic [31:0] rd;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= LIMIT_ADDR;
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    limit_reg = value;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd !== 32'(value))
      report_mismatch($sformatf("max_out_len read %0h exp %0h", rd, value));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // field extremes, every op kind, every way a frame can end
  task automatic test_directed_frames();
    // lit 00, match d1 L18, lit FF, match d4095 L18 (unwritten), lit A5,
    // match d0 L3 (unwritten), match d3 L5, lit 3C
    send_frame('{8'h56, 8'h00, 8'h0F, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hA5,
                 8'h00, 8'h00, 8'h02, 8'h03, 8'h3C});
    // ends right after a control byte
    send_frame('{8'hFF});
    // match cut after its first byte
    send_frame('{8'h80, 8'h12});
    // frame closes on the second match byte
    send_frame('{8'h80, 8'h30, 8'h05});
    // eight literals, then a control byte closes the frame
    send_frame('{8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40,
                 8'h80, 8'h7E});
  endtask

  task automatic test_output_limit();
    drain_output();
    write_limit('0);
    // literal over the limit, then ignored bytes
    send_frame('{8'h00, 8'h11, 8'h22, 8'h33});
    // match over the limit on the closing byte
    send_frame('{8'h80, 8'h0F, 8'h01});
    // literal over the limit on the closing byte
    send_frame('{8'h00, 8'h44});
    drain_output();
    write_limit(24'd5);
    // match reaches the limit exactly, next literal overflows
    send_frame('{8'h40, 8'h61, 8'h01, 8'h01, 8'h62, 8'h63, 8'h64});
    // match crosses the limit mid-frame
    send_frame('{8'h10, 8'h71, 8'h72, 8'h73, 8'h00, 8'h02, 8'h55});
    drain_output();
    write_limit(LIMIT_TOP);
    send_frame('{8'h20, 8'hDE, 8'hAD, 8'h0F, 8'h02});
    drain_output();
    write_limit(MAX_OUT_LEN_RESET);
  endtask

  // well-formed frames with random content, some cut anywhere, some noise
  task automatic send_random_frames(input int unsigned n_words);
    logic [7:0]  frame[$];
    logic [7:0]  ctrl;
    logic [11:0] distance;
    int unsigned target;
    int unsigned n_ops;
    int unsigned cut;
    int          bi;
    target = words_sent + n_words;
    while (words_sent < target) begin
      frame.delete();
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(12, 1)) frame.push_back(8'($urandom));
      end else begin
        n_ops = $urandom_range(20, 1);
        while (n_ops > 0) begin
          ctrl = 8'($urandom);
          frame.push_back(ctrl);
          for (bi = 7; bi >= 0 && n_ops > 0; bi--) begin
            if (ctrl[bi]) begin
              case ($urandom_range(9))
                0:       distance = 12'd0;
                1, 2:    distance = 12'($urandom);
                default: distance = 12'($urandom_range(24, 1));
              endcase
              frame.push_back({distance[11:8], 4'($urandom)});
              frame.push_back(distance[7:0]);
            end else begin
              frame.push_back(8'($urandom));
            end
            n_ops--;
          end
        end
        // a quarter of the frames end at a random byte
        if ($urandom_range(3) == 0) begin
          cut = $urandom_range(frame.size() - 1);
          while (frame.size() > cut + 1) void'(frame.pop_back());
        end
      end
      send_frame(frame);
    end
  endtask

  task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct,
                                     input int unsigned n_words, input logic [COUNT_W-1:0] lim);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    drain_output();
    write_limit(lim);
    send_random_frames(n_words / 2);
    // tight limit so overflow shows up often
    drain_output();
    write_limit(COUNT_W'($urandom_range(200, 8)));
    send_random_frames(n_words - n_words / 2);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin : run
    int unsigned waited;
    limit_reg = MAX_OUT_LEN_RESET;
    restart_frame();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_frames();
    test_output_limit();
    test_random_traffic(37, 62, 110, MAX_OUT_LEN_RESET);
    test_random_traffic(62, 37, 110, LIMIT_TOP);
    test_random_traffic(0, 0, 110, MAX_OUT_LEN_RESET);

    // wait for the tail, bounded
    in_valid <= 1'b0;
    waited = 0;
    while (decoded_q.size() != 0 && waited < DRAIN_CYCLES) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (decoded_q.size() != 0)
      report_mismatch($sformatf("%0d output words never arrived", decoded_q.size()));

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: lzss_decompressor_core.f
+incdir+rtl
rtl/lzss_pkg.sv
rtl/lzss_ram.sv
rtl/lzss_front.sv
rtl/lzss_cmd_fifo.sv
rtl/lzss_back.sv
rtl/lzss_decompressor_core.sv
rtl/lzss_chk.sv
tb/lzss_decompressor_core_tb.sv
